>>> hdl/cswq_pkg.sv
// ----------------------------------------------------------------------------
// cswq_pkg
// Shared codes, state type and controller/datapath interface structs for the
// counting semaphore with a linked-list wait queue.
// ----------------------------------------------------------------------------
package cswq_pkg;

  localparam int CFG_BITS = 16;

  // register indexes
  localparam logic REG_INITIAL_COUNT = 1'b0;
  localparam logic REG_MAX_COUNT     = 1'b1;

  // request actions
  localparam logic [2:0] ACT_ACQUIRE = 3'd0;
  localparam logic [2:0] ACT_TRY     = 3'd1;
  localparam logic [2:0] ACT_RELEASE = 3'd2;
  localparam logic [2:0] ACT_CANCEL  = 3'd3;
  localparam logic [2:0] ACT_QUERY   = 3'd4;

  // result status codes
  localparam logic [2:0] RES_GRANTED   = 3'd0;
  localparam logic [2:0] RES_QUEUED    = 3'd1;
  localparam logic [2:0] RES_BUSY      = 3'd2;
  localparam logic [2:0] RES_HANDED    = 3'd3;
  localparam logic [2:0] RES_RAISED    = 3'd4;
  localparam logic [2:0] RES_CANCELLED = 3'd5;
  localparam logic [2:0] RES_NOEFFECT  = 3'd6;
  localparam logic [2:0] RES_DUPLICATE = 3'd7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_ENQ_LINK,
    S_ENQ_TAIL,
    S_UNLINK,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       load_item;
    logic       rd_en;
    logic       rd_head;
    logic       dec_count;
    logic       inc_count;
    logic       enq_single;
    logic       enq_link;
    logic       enq_tail;
    logic       unlink;
    logic       out_load;
    logic [2:0] res;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] action;
    logic       id_ok;
    logic       pending;
    logic       cnt_pos;
    logic       q_nonempty;
    logic       can_raise;
    logic       out_free;
  } stat_t;

endpackage

>>> hdl/cswq_ctrl.sv
// ----------------------------------------------------------------------------
// cswq_ctrl
// Sequencer for one request: decides the outcome, steps the link table
// updates and hands the result to the output register.
// ----------------------------------------------------------------------------
module cswq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cswq_pkg::stat_t stat,
  output cswq_pkg::cmd_t  cmd
);
  import cswq_pkg::*;

  state_t     state, state_next;
  logic [2:0] res, res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res   <= RES_NOEFFECT;
    end else begin
      state <= state_next;
      res   <= res_next;
    end
  end

  always_comb begin
    state_next = state;
    res_next   = res;
    cmd        = '0;
    cmd.res    = res;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_DONE;
        res_next   = RES_NOEFFECT;
        unique case (stat.action)
          ACT_ACQUIRE: begin
            if (!stat.id_ok) begin
              res_next = RES_NOEFFECT;
            end else if (stat.pending) begin
              res_next = RES_DUPLICATE;
            end else if (stat.cnt_pos) begin
              cmd.dec_count = 1'b1;
              res_next      = RES_GRANTED;
            end else if (stat.q_nonempty) begin
              cmd.rd_en   = 1'b1;
              cmd.rd_head = 1'b1;
              res_next    = RES_QUEUED;
              state_next  = S_ENQ_LINK;
            end else begin
              cmd.enq_single = 1'b1;
              res_next       = RES_QUEUED;
            end
          end
          ACT_TRY: begin
            if (stat.cnt_pos) begin
              cmd.dec_count = 1'b1;
              res_next      = RES_GRANTED;
            end else begin
              res_next = RES_BUSY;
            end
          end
          ACT_RELEASE: begin
            if (stat.q_nonempty) begin
              cmd.rd_en   = 1'b1;
              cmd.rd_head = 1'b1;
              res_next    = RES_HANDED;
              state_next  = S_UNLINK;
            end else if (stat.can_raise) begin
              cmd.inc_count = 1'b1;
              res_next      = RES_RAISED;
            end else begin
              res_next = RES_NOEFFECT;
            end
          end
          ACT_CANCEL: begin
            if (stat.id_ok && stat.pending) begin
              cmd.rd_en  = 1'b1;
              res_next   = RES_CANCELLED;
              state_next = S_UNLINK;
            end else begin
              res_next = RES_NOEFFECT;
            end
          end
          default: res_next = RES_NOEFFECT;
        endcase
      end
      S_ENQ_LINK: begin
        cmd.enq_link = 1'b1;
        state_next   = S_ENQ_TAIL;
      end
      S_ENQ_TAIL: begin
        cmd.enq_tail = 1'b1;
        state_next   = S_DONE;
      end
      S_UNLINK: begin
        cmd.unlink = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> hdl/cswq_dp.sv
// ----------------------------------------------------------------------------
// cswq_dp
// Datapath: count and limit registers, queue head, pending flags, the next
// and previous link tables and the result register.
// ----------------------------------------------------------------------------
module cswq_dp #(
  parameter int MAX_WAITERS = 16,
  parameter int COUNT_BITS  = 16,
  parameter int ID_W        = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_idx,
  input  logic [cswq_pkg::CFG_BITS-1:0] cfg_wdata,
  input  logic [2:0]                    action,
  input  logic [ID_W-1:0]               waiter_id,
  input  cswq_pkg::cmd_t                cmd,
  output cswq_pkg::stat_t               stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    status,
  output logic                          woken_valid,
  output logic [ID_W-1:0]               woken_id,
  output logic [COUNT_BITS-1:0]         count_now,
  output logic                          waiter_pending
);
  import cswq_pkg::*;

  logic [CFG_BITS-1:0]    max_count;
  logic [COUNT_BITS-1:0]  unit_count;
  logic                   queue_nonempty;
  logic [ID_W-1:0]        queue_head;
  logic [MAX_WAITERS-1:0] pending_flags;

  logic [2:0]      cur_action;
  logic [ID_W-1:0] cur_id;
  logic [ID_W-1:0] victim;
  logic [ID_W-1:0] rd_next, rd_prev;

  logic [ID_W-1:0] next_mem [MAX_WAITERS];
  logic [ID_W-1:0] prev_mem [MAX_WAITERS];

  logic            id_ok;
  logic            cur_pending;
  logic [ID_W-1:0] rd_addr;
  logic            next_we, prev_we;
  logic [ID_W-1:0] next_waddr, next_wdata, prev_waddr, prev_wdata;

  assign id_ok = {1'b0, cur_id} < (ID_W + 1)'(MAX_WAITERS);
  assign cur_pending = id_ok && pending_flags[cur_id];
  assign rd_addr = cmd.rd_head ? queue_head : cur_id;

  always_comb begin
    stat.action     = cur_action;
    stat.id_ok      = id_ok;
    stat.pending    = cur_pending;
    stat.cnt_pos    = unit_count != '0;
    stat.q_nonempty = queue_nonempty;
    stat.can_raise  = ({{CFG_BITS{1'b0}}, unit_count} <
                       {{COUNT_BITS{1'b0}}, max_count}) && (unit_count != '1);
    stat.out_free   = !out_valid || out_ready;
  end

  // link table write ports
  always_comb begin
    next_we    = 1'b0;
    prev_we    = 1'b0;
    next_waddr = cur_id;
    next_wdata = cur_id;
    prev_waddr = cur_id;
    prev_wdata = cur_id;
    if (cmd.enq_single) begin
      next_we = 1'b1;
      prev_we = 1'b1;
    end else if (cmd.enq_link) begin
      next_we    = 1'b1;
      prev_we    = 1'b1;
      next_wdata = queue_head;
      prev_wdata = rd_prev;
    end else if (cmd.enq_tail) begin
      next_we    = 1'b1;
      prev_we    = 1'b1;
      next_waddr = rd_prev;
      prev_waddr = queue_head;
    end else if (cmd.unlink) begin
      next_we    = 1'b1;
      prev_we    = 1'b1;
      next_waddr = rd_prev;
      next_wdata = rd_next;
      prev_waddr = rd_next;
      prev_wdata = rd_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    if (cmd.rd_en) begin
      rd_next <= next_mem[rd_addr];
      rd_prev <= prev_mem[rd_addr];
      victim  <= rd_addr;
    end
    if (cmd.load_item) begin
      cur_action <= action;
      cur_id     <= waiter_id;
    end
  end

  // semaphore state
  always_ff @(posedge clk) begin
    if (rst) begin
      max_count      <= '1;
      unit_count     <= COUNT_BITS'(1);
      queue_nonempty <= 1'b0;
      queue_head     <= '0;
      pending_flags  <= '0;
    end else if (cfg_we) begin
      if (cfg_idx == REG_INITIAL_COUNT) begin
        unit_count     <= COUNT_BITS'({{COUNT_BITS{1'b0}}, cfg_wdata});
        queue_nonempty <= 1'b0;
        queue_head     <= '0;
        pending_flags  <= '0;
      end else begin
        max_count <= cfg_wdata;
      end
    end else begin
      if (cmd.dec_count) begin
        unit_count <= unit_count - COUNT_BITS'(1);
      end else if (cmd.inc_count) begin
        unit_count <= unit_count + COUNT_BITS'(1);
      end
      if (cmd.enq_single) begin
        queue_head             <= cur_id;
        queue_nonempty         <= 1'b1;
        pending_flags[cur_id]  <= 1'b1;
      end
      if (cmd.enq_link) begin
        pending_flags[cur_id] <= 1'b1;
      end
      if (cmd.unlink) begin
        pending_flags[victim] <= 1'b0;
        if (queue_head == victim) begin
          if (rd_next == victim) begin
            queue_nonempty <= 1'b0;
            queue_head     <= '0;
          end else begin
            queue_head <= rd_next;
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status         <= cmd.res;
      woken_valid    <= cmd.res == RES_HANDED;
      woken_id       <= (cmd.res == RES_HANDED) ? victim : '0;
      count_now      <= unit_count;
      waiter_pending <= cur_pending;
    end
  end

endmodule

>>> hdl/counting_semaphore_wait_queue.sv
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue
// Counting semaphore with a FIFO wait queue of waiter ids kept as a circular
// doubly linked list. One request in, one result out. Each request passes a
// decide and a done step; a release that hands over or a cancel adds an
// unlink step, and an acquire that joins a non-empty queue adds a link and
// a tail step, as the link tables have a registered read port and a single
// write port each. A request is taken once the last result is loaded, while
// that result waits in the output register. Writing initial_count reloads
// the count and empties the queue at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module counting_semaphore_wait_queue #(
  parameter int MAX_WAITERS = 16,
  parameter int COUNT_BITS  = 16,
  parameter int ID_W        = $clog2(MAX_WAITERS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_idx,
  input  logic [cswq_pkg::CFG_BITS-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    action,
  input  logic [ID_W-1:0]               waiter_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    status,
  output logic                          woken_valid,
  output logic [ID_W-1:0]               woken_id,
  output logic [COUNT_BITS-1:0]         count_now,
  output logic                          waiter_pending
);
  import cswq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  cswq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cswq_dp #(
    .MAX_WAITERS (MAX_WAITERS),
    .COUNT_BITS  (COUNT_BITS),
    .ID_W        (ID_W)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .action         (action),
    .waiter_id      (waiter_id),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .woken_valid    (woken_valid),
    .woken_id       (woken_id),
    .count_now      (count_now),
    .waiter_pending (waiter_pending)
  );

endmodule

>>> tb/counting_semaphore_wait_queue_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue_test
// Self-checking bench for the counting semaphore with its linked-list wait
// queue. A short scripted sequence walks grants, queueing, duplicates,
// cancels of a middle, a tail and a lone waiter, handovers,
// saturation and the spare action codes under several register settings.
// Random phases follow, each under a new setting. Every request goes
// through a local semaphore model, and each result transaction is compared
// field by field in arrival order. Random gaps on the request side and
// random stalls on the result side exercise the handshakes.
// ----------------------------------------------------------------------------
module counting_semaphore_wait_queue_test;
  import cswq_pkg::*;

  localparam logic [2:0] ACT_SPARE_5 = 3'd5;
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;
  localparam int SCRIPT_LEN   = 31;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 190;
  localparam int IDLE_LIMIT   = 3000;
  localparam int SETTLE_TICKS = 8;

  typedef struct packed {
    logic [2:0]  status;
    logic        woken_valid;
    logic [3:0]  woken_id;
    logic [15:0] count_now;
    logic        waiter_pending;
  } answer_t;

  typedef struct packed {
    logic        is_cfg;
    logic        cfg_reg;
    logic [15:0] cfg_val;
    logic [2:0]  act;
    logic [3:0]  wid;
    logic        typed;
    answer_t     ans;
  } step_row_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic                cfg_idx;
  logic [CFG_BITS-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic [2:0]          action;
  logic [3:0]          waiter_id;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [2:0]          status;
  logic                woken_valid;
  logic [3:0]          woken_id;
  logic [15:0]         count_now;
  logic                waiter_pending;

  // semaphore model state
  logic [15:0] sem_count;
  logic [15:0] cfg_init;
  logic [15:0] cfg_max;
  logic        wq_nonempty;
  logic [3:0]  wq_head;
  logic [3:0]  wq_next [16];
  logic [3:0]  wq_prev [16];
  logic [15:0] wq_pending;

  answer_t   answer_q [$];
  answer_t   want;
  step_row_t script [SCRIPT_LEN];

  int fail_count;
  int n_sent;
  int n_checked;
  int n_handed;
  int n_queued;
  int n_cancelled;
  int n_duplicate;
  int n_writes;
  int idle_cycles;
  int stall_left;
  bit fast_in;
  bit rx_no_stall;

  counting_semaphore_wait_queue dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .waiter_id      (waiter_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .woken_valid    (woken_valid),
    .woken_id       (woken_id),
    .count_now      (count_now),
    .waiter_pending (waiter_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] exp_val);
    $display("mismatch on %s at result %0d: got %0d expected %0d",
             field, n_checked, got, exp_val);
    fail_count++;
  endtask

  task automatic wq_unlink(input logic [3:0] w);
    logic [3:0] n;
    logic [3:0] p;
    n = wq_next[w];
    p = wq_prev[w];
    wq_next[p] = n;
    wq_prev[n] = p;
    if (wq_head == w) begin
      if (n == w) begin
        wq_nonempty = 1'b0;
        wq_head = '0;
      end else begin
        wq_head = n;
      end
    end
    wq_pending[w] = 1'b0;
  endtask

  task automatic sem_step(input logic [2:0] act, input logic [3:0] wid,
                          output answer_t a);
    logic [3:0] h;
    a = '0;
    a.status = RES_NOEFFECT;
    case (act)
      ACT_ACQUIRE: begin
        if (wq_pending[wid]) begin
          a.status = RES_DUPLICATE;
        end else if (sem_count != '0) begin
          sem_count = sem_count - 16'd1;
          a.status = RES_GRANTED;
        end else begin
          if (wq_nonempty) begin
            h = wq_prev[wq_head];
            wq_next[wid] = wq_head;
            wq_prev[wid] = h;
            wq_next[h] = wid;
            wq_prev[wq_head] = wid;
          end else begin
            wq_next[wid] = wid;
            wq_prev[wid] = wid;
            wq_head = wid;
            wq_nonempty = 1'b1;
          end
          wq_pending[wid] = 1'b1;
          a.status = RES_QUEUED;
        end
      end
      ACT_TRY: begin
        if (sem_count != '0) begin
          sem_count = sem_count - 16'd1;
          a.status = RES_GRANTED;
        end else begin
          a.status = RES_BUSY;
        end
      end
      ACT_RELEASE: begin
        if (wq_nonempty) begin
          h = wq_head;
          wq_unlink(h);
          a.status = RES_HANDED;
          a.woken_valid = 1'b1;
          a.woken_id = h;
        end else if (sem_count < cfg_max && sem_count != 16'hFFFF) begin
          sem_count = sem_count + 16'd1;
          a.status = RES_RAISED;
        end
      end
      ACT_CANCEL: begin
        if (wq_pending[wid]) begin
          wq_unlink(wid);
          a.status = RES_CANCELLED;
        end
      end
      default: begin
      end
    endcase
    a.count_now = sem_count;
    a.waiter_pending = wq_pending[wid];
  endtask

  function automatic int pick_gap(input bit no_gaps);
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [3:0] pick_cancel_id();
    int n;
    int k;
    n = $countones(wq_pending);
    if (n == 0 || $urandom_range(0, 9) < 3) return 4'($urandom_range(0, 15));
    k = $urandom_range(0, n - 1);
    for (int i = 0; i < 16; i++) begin
      if (wq_pending[i]) begin
        if (k == 0) return 4'(i);
        k--;
      end
    end
    return '0;
  endfunction

  function automatic step_row_t req(input logic [2:0] act, input logic [3:0] wid);
    step_row_t s;
    s = '0;
    s.act = act;
    s.wid = wid;
    return s;
  endfunction

  function automatic step_row_t req_ans(input logic [2:0] act, input logic [3:0] wid,
                                        input logic [2:0] st, input logic wv,
                                        input logic [3:0] wi, input logic [15:0] cnt,
                                        input logic pend);
    step_row_t s;
    s = req(act, wid);
    s.typed = 1'b1;
    s.ans.status = st;
    s.ans.woken_valid = wv;
    s.ans.woken_id = wi;
    s.ans.count_now = cnt;
    s.ans.waiter_pending = pend;
    return s;
  endfunction

  function automatic step_row_t reg_wr(input logic r, input logic [15:0] v);
    step_row_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.cfg_reg = r;
    s.cfg_val = v;
    return s;
  endfunction

  task automatic send_req(input logic [2:0] act, input logic [3:0] wid,
                          input logic typed, input answer_t ans);
    int gap;
    answer_t p;
    gap = pick_gap(fast_in);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    waiter_id <= wid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sem_step(act, wid, p);
    answer_q.push_back(typed ? ans : p);
    n_sent++;
  endtask

  // hold requests until every result is back, then let the block settle
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_reg(input logic r, input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= r;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (r == REG_INITIAL_COUNT) begin
      cfg_init    = v;
      sem_count   = v;
      wq_nonempty = 1'b0;
      wq_head     = '0;
      wq_pending  = '0;
    end else begin
      cfg_max = v;
    end
    n_writes++;
  endtask

  // result side: check and random stalls
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (answer_q.size() == 0) begin
        report_mismatch("unexpected transaction", '0, '0);
      end else begin
        want = answer_q.pop_front();
        if (status !== want.status)
          report_mismatch("status", 16'(status), 16'(want.status));
        if (woken_valid !== want.woken_valid)
          report_mismatch("woken_valid", 16'(woken_valid), 16'(want.woken_valid));
        if (woken_id !== want.woken_id)
          report_mismatch("woken_id", 16'(woken_id), 16'(want.woken_id));
        if (count_now !== want.count_now)
          report_mismatch("count_now", count_now, want.count_now);
        if (waiter_pending !== want.waiter_pending)
          report_mismatch("waiter_pending", 16'(waiter_pending),
                          16'(want.waiter_pending));
        n_checked++;
        if (want.status == RES_HANDED) n_handed++;
        if (want.status == RES_QUEUED) n_queued++;
        if (want.status == RES_CANCELLED) n_cancelled++;
        if (want.status == RES_DUPLICATE) n_duplicate++;
      end
    end
    if (rx_no_stall) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 65) begin
      out_ready <= 1'b1;
    end else begin
      stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                  : $urandom_range(3, 40);
      out_ready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("counting_semaphore_wait_queue regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [2:0] act;
    logic [3:0] wid;
    int         r;
    int         acq_w;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_idx   <= REG_INITIAL_COUNT;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    action    <= ACT_ACQUIRE;
    waiter_id <= '0;
    cfg_init    = 16'd1;
    cfg_max     = 16'hFFFF;
    sem_count   = cfg_init;
    wq_nonempty = 1'b0;
    wq_head     = '0;
    wq_pending  = '0;
    for (int i = 0; i < 16; i++) begin
      wq_next[i] = '0;
      wq_prev[i] = '0;
    end

    // queue ends up 3, 15, 0; cancel from the middle and the tail
    script[0]  = req_ans(ACT_TRY, 4'd0, RES_GRANTED, 1'b0, 4'd0, 16'd0, 1'b0);
    script[1]  = req_ans(ACT_TRY, 4'd9, RES_BUSY, 1'b0, 4'd0, 16'd0, 1'b0);
    script[2]  = req_ans(ACT_ACQUIRE, 4'd3, RES_QUEUED, 1'b0, 4'd0, 16'd0, 1'b1);
    script[3]  = req_ans(ACT_ACQUIRE, 4'd3, RES_DUPLICATE, 1'b0, 4'd0, 16'd0, 1'b1);
    script[4]  = req(ACT_ACQUIRE, 4'd15);
    script[5]  = req(ACT_ACQUIRE, 4'd0);
    script[6]  = req(ACT_QUERY, 4'd15);
    script[7]  = req(ACT_CANCEL, 4'd15);
    script[8]  = req_ans(ACT_CANCEL, 4'd15, RES_NOEFFECT, 1'b0, 4'd0, 16'd0, 1'b0);
    script[9]  = req(ACT_CANCEL, 4'd0);
    script[10] = req_ans(ACT_RELEASE, 4'd3, RES_HANDED, 1'b1, 4'd3, 16'd0, 1'b0);
    script[11] = req(ACT_RELEASE, 4'd0);
    script[12] = req_ans(ACT_SPARE_5, 4'd0, RES_NOEFFECT, 1'b0, 4'd0, 16'd1, 1'b0);
    script[13] = req_ans(ACT_SPARE_6, 4'd15, RES_NOEFFECT, 1'b0, 4'd0, 16'd1, 1'b0);
    script[14] = req_ans(ACT_SPARE_7, 4'd0, RES_NOEFFECT, 1'b0, 4'd0, 16'd1, 1'b0);
    // mutex
    script[15] = reg_wr(REG_MAX_COUNT, 16'd1);
    script[16] = req_ans(ACT_RELEASE, 4'd0, RES_NOEFFECT, 1'b0, 4'd0, 16'd1, 1'b0);
    script[17] = req(ACT_ACQUIRE, 4'd8);
    script[18] = req(ACT_ACQUIRE, 4'd12);
    script[19] = req(ACT_RELEASE, 4'd12);
    // full scale
    script[20] = reg_wr(REG_INITIAL_COUNT, 16'hFFFF);
    script[21] = reg_wr(REG_MAX_COUNT, 16'hFFFF);
    script[22] = req_ans(ACT_RELEASE, 4'd0, RES_NOEFFECT, 1'b0, 4'd0, 16'hFFFF, 1'b0);
    script[23] = req(ACT_TRY, 4'd5);
    // count above the maximum
    script[24] = reg_wr(REG_MAX_COUNT, 16'd2);
    script[25] = reg_wr(REG_INITIAL_COUNT, 16'd7);
    script[26] = req_ans(ACT_RELEASE, 4'd0, RES_NOEFFECT, 1'b0, 4'd0, 16'd7, 1'b0);
    // empty semaphore, lone waiter cancelled
    script[27] = reg_wr(REG_INITIAL_COUNT, 16'd0);
    script[28] = req(ACT_ACQUIRE, 4'd1);
    script[29] = req(ACT_CANCEL, 4'd1);
    script[30] = req(ACT_QUERY, 4'd1);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (script[i].is_cfg) begin
        settle_idle();
        write_reg(script[i].cfg_reg, script[i].cfg_val);
      end else begin
        send_req(script[i].act, script[i].wid, script[i].typed, script[i].ans);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle_idle();
      case ($urandom_range(0, 3))
        0: write_reg(REG_MAX_COUNT, 16'd1);
        1: write_reg(REG_MAX_COUNT, 16'hFFFF);
        default: write_reg(REG_MAX_COUNT, 16'($urandom_range(1, 4)));
      endcase
      case ($urandom_range(0, 5))
        0: write_reg(REG_INITIAL_COUNT, 16'd0);
        1: write_reg(REG_INITIAL_COUNT, 16'hFFFF);
        default: write_reg(REG_INITIAL_COUNT, 16'($urandom_range(0, 3)));
      endcase
      fast_in     = (ph % 3 == 1);
      rx_no_stall = (ph % 3 == 2);
      acq_w       = 28 + $urandom_range(0, 20);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 199) == 0) settle_idle();
        r   = $urandom_range(0, 99);
        wid = 4'($urandom_range(0, 15));
        if (r < acq_w) begin
          act = ACT_ACQUIRE;
        end else if (r < acq_w + 10) begin
          act = ACT_TRY;
        end else if (r < acq_w + 36) begin
          act = ACT_RELEASE;
        end else if (r < acq_w + 48) begin
          act = ACT_CANCEL;
          wid = pick_cancel_id();
        end else if (r < 96) begin
          act = ACT_QUERY;
        end else begin
          act = 3'($urandom_range(5, 7));
        end
        send_req(act, wid, 1'b0, '0);
      end
    end

    settle_idle();
    $display("covered %0d requests, %0d results checked, %0d register writes",
             n_sent, n_checked, n_writes);
    $display("handovers %0d, queued waiters %0d, cancels %0d, duplicate acquires %0d",
             n_handed, n_queued, n_cancelled, n_duplicate);
    if (fail_count == 0 && answer_q.size() == 0) begin
      $display("counting_semaphore_wait_queue regression: pass");
    end else begin
      $display("counting_semaphore_wait_queue regression: fail");
    end
    $finish;
  end

endmodule
